/* rtl/alternating_sign_range_sum_tree_unit_assert.svh */
// Assertion macros shared by the range sum tree modules.
`ifndef ALTERNATING_SIGN_RANGE_SUM_TREE_UNIT_ASSERT_SVH
`define ALTERNATING_SIGN_RANGE_SUM_TREE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define ASRST_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define ASRST_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/asrst_pkg.sv */
// Shared constants and controller/datapath interface types of the range sum tree.
`timescale 1ns / 1ps
package asrst_pkg;

    localparam int MAX_LEAVES = 1024;
    localparam int LEAF_BITS  = $clog2(MAX_LEAVES);
    localparam int NODE_BITS  = LEAF_BITS + 1;
    localparam int PTR_BITS   = NODE_BITS + 1;
    localparam int NODES      = 2 * MAX_LEAVES;

    localparam int POS_W   = 10;
    localparam int VAL_W   = 32;
    localparam int END_W   = 11;
    localparam int CNT_W   = 11;
    localparam int SUM_W   = 64;
    localparam int IN_TDATA_W = 56;

    localparam logic [CNT_W-1:0] COUNT_RESET = CNT_W'(MAX_LEAVES);
    localparam logic REQ_UPDATE = 1'b0;
    localparam logic REQ_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic clr_step;  // write zero at the sweep address and advance
        logic load_req;  // capture an accepted request
        logic up_leaf;   // write the leaf, read its sibling
        logic up_step;   // write a parent sum, read the parent's sibling
        logic acc_pend;  // fold pending read data into the accumulator
        logic rd_l;      // left bound step of a query
        logic rd_r;      // right bound step of a query, then halve both bounds
        logic load_out;  // move the finished sum to the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clr_last;
        logic is_query;
        logic upd_ok;
        logic l_lt_r;
        logic root_next;
    } t_stat;

endpackage

/* rtl/asrst_dpath.sv */
// Datapath of the range sum tree: node memory, bounds, accumulator and result register.
`timescale 1ns / 1ps
`include "alternating_sign_range_sum_tree_unit_assert.svh"
module asrst_dpath
    import asrst_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cmd                    i_cmd,
    input  logic [CNT_W-1:0]        i_element_count,
    input  logic                    i_req_type,
    input  logic [POS_W-1:0]        i_position,
    input  logic signed [VAL_W-1:0] i_new_value,
    input  logic [END_W-1:0]        i_range_end,
    output t_stat                   o_stat,
    output logic signed [SUM_W-1:0] o_range_sum
);

    logic [SUM_W-1:0]     r_mem [NODES];
    logic [SUM_W-1:0]     r_rdata;
    logic [NODE_BITS-1:0] r_clr;
    logic [NODE_BITS-1:0] r_node;
    logic [PTR_BITS-1:0]  r_l, n_l;
    logic [PTR_BITS-1:0]  r_r, n_r;
    logic [SUM_W-1:0]     r_acc, n_acc;
    logic                 r_pend, n_pend;
    logic                 r_neg;
    logic [SUM_W-1:0]     r_out;

    logic [CNT_W-1:0]     w_count;
    logic [END_W-1:0]     w_end;
    logic [SUM_W-1:0]     w_leaf;
    logic [SUM_W-1:0]     w_sum;
    logic [SUM_W-1:0]     w_acc_in;
    logic                 w_we;
    logic [NODE_BITS-1:0] w_waddr;
    logic [SUM_W-1:0]     w_wdata;
    logic [NODE_BITS-1:0] w_raddr;

    always_comb begin
        w_count = (i_element_count > COUNT_RESET) ? COUNT_RESET : i_element_count;
        w_end   = (i_range_end > w_count) ? w_count : i_range_end;
        w_leaf  = {{(SUM_W-VAL_W){i_new_value[VAL_W-1]}}, i_new_value};
        if (i_position[0]) begin
            w_leaf = SUM_W'(0) - w_leaf;
        end
        w_sum    = r_acc + r_rdata;
        w_acc_in = r_pend ? w_sum : r_acc;
    end

    // Memory port selection.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_clr;
        w_wdata = '0;
        w_raddr = {r_node[NODE_BITS-1:1], ~r_node[0]};
        if (i_cmd.clr_step) begin
            w_we = 1'b1;
        end else if (i_cmd.up_leaf) begin
            w_we    = 1'b1;
            w_waddr = r_node;
            w_wdata = r_acc;
        end else if (i_cmd.up_step) begin
            w_we    = 1'b1;
            w_waddr = {1'b0, r_node[NODE_BITS-1:1]};
            w_wdata = w_sum;
            w_raddr = {1'b0, r_node[NODE_BITS-1:2], ~r_node[1]};
        end
        if (i_cmd.rd_l) begin
            w_raddr = r_l[NODE_BITS-1:0];
        end else if (i_cmd.rd_r) begin
            w_raddr = {r_r[NODE_BITS-1:1], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clr_step) begin
            r_clr <= r_clr + NODE_BITS'(1);
        end
    end

    always_comb begin
        n_l    = r_l;
        n_r    = r_r;
        n_acc  = r_acc;
        n_pend = r_pend;
        if (i_cmd.acc_pend) begin
            n_acc  = w_acc_in;
            n_pend = 1'b0;
        end
        if (i_cmd.rd_l && r_l[0]) begin
            n_l    = r_l + PTR_BITS'(1);
            n_pend = 1'b1;
        end
        if (i_cmd.rd_r) begin
            n_pend = r_r[0];
            n_l    = r_l >> 1;
            n_r    = r_r >> 1;
        end
        if (i_cmd.up_step) begin
            n_acc = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_req) begin
            r_node <= {1'b1, i_position};
            r_l    <= PTR_BITS'({1'b1, i_position});
            r_r    <= PTR_BITS'(w_end) + PTR_BITS'(MAX_LEAVES);
            r_acc  <= (i_req_type == REQ_UPDATE) ? w_leaf : '0;
            r_pend <= 1'b0;
            r_neg  <= i_position[0];
        end else begin
            if (i_cmd.up_leaf || i_cmd.up_step) begin
                r_node <= i_cmd.up_step ? {1'b0, r_node[NODE_BITS-1:1]} : r_node;
            end
            r_l    <= n_l;
            r_r    <= n_r;
            r_acc  <= n_acc;
            r_pend <= n_pend;
        end
        if (i_cmd.load_out) begin
            r_out <= r_neg ? (SUM_W'(0) - r_acc) : r_acc;
        end
    end

    always_comb begin
        o_stat.clr_last  = &r_clr;
        o_stat.is_query  = (i_req_type == REQ_QUERY);
        o_stat.upd_ok    = (CNT_W'(i_position) < w_count);
        o_stat.l_lt_r    = (r_l < r_r);
        o_stat.root_next = (r_node[NODE_BITS-1:1] == (NODE_BITS-1)'(1));
    end

    assign o_range_sum = r_out;

    `ASRST_ASSERT_IMP(a_rd_l_in_range, i_clk, i_rst_n, i_cmd.rd_l, r_l < r_r, "left read beyond right bound")
    `ASRST_ASSERT_IMP(a_up_not_root, i_clk, i_rst_n, i_cmd.up_step, r_node > NODE_BITS'(1), "sum walk passed the root")

endmodule

/* rtl/asrst_ctrl.sv */
// Controller of the range sum tree: clearing sweep, update walk and query walk.
`timescale 1ns / 1ps
`include "alternating_sign_range_sum_tree_unit_assert.svh"
module asrst_ctrl
    import asrst_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_s_valid,
    input  logic  i_m_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  o_s_ready,
    output logic  o_m_valid
);

    typedef enum logic [6:0] {
        S_CLEAR   = 7'b0000001,
        S_IDLE    = 7'b0000010,
        S_UP_LEAF = 7'b0000100,
        S_UP_STEP = 7'b0001000,
        S_Q_L     = 7'b0010000,
        S_Q_R     = 7'b0100000,
        S_Q_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_m_valid, n_m_valid;
    logic   w_fire;
    logic   w_out_free;

    assign o_s_ready  = (r_state == S_IDLE);
    assign w_fire     = i_s_valid && o_s_ready;
    assign w_out_free = !r_m_valid || i_m_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        o_cmd.load_req = w_fire;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (w_fire) begin
                    if (i_stat.is_query) begin
                        n_state = S_Q_L;
                    end else if (i_stat.upd_ok) begin
                        n_state = S_UP_LEAF;
                    end
                end
            end
            S_UP_LEAF: begin
                o_cmd.up_leaf = 1'b1;
                n_state = S_UP_STEP;
            end
            S_UP_STEP: begin
                o_cmd.up_step = 1'b1;
                if (i_stat.root_next) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_L: begin
                o_cmd.acc_pend = 1'b1;
                if (i_stat.l_lt_r) begin
                    o_cmd.rd_l = 1'b1;
                    n_state = S_Q_R;
                end else begin
                    n_state = S_Q_OUT;
                end
            end
            S_Q_R: begin
                o_cmd.acc_pend = 1'b1;
                o_cmd.rd_r = 1'b1;
                n_state = S_Q_L;
            end
            S_Q_OUT: begin
                if (w_out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_m_valid = r_m_valid;
        if (r_m_valid && i_m_ready) begin
            n_m_valid = 1'b0;
        end
        if (o_cmd.load_out) begin
            n_m_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    assign o_m_valid = r_m_valid;

    `ASRST_ASSERT_IMP(a_load_when_free, i_clk, i_rst_n, o_cmd.load_out, w_out_free, "result loaded over an untaken result")
    `ASRST_ASSERT_NXT(a_clear_once, i_clk, i_rst_n, r_state != S_CLEAR, r_state != S_CLEAR, "clearing sweep re-entered")

endmodule

/* rtl/alternating_sign_range_sum_tree_unit.sv */
// Top level of the alternating-sign range sum tree with stream and APB ports.
//
//  Channel   | Direction | Content
//  ----------+-----------+----------------------------------------------------
//  s stream  | in        | tuser: req_type; tdata: position, new_value, range_end
//  m stream  | out       | tdata: range_sum
//  APB       | in/out    | element_count at byte address 0
//
// An update request first writes the leaf, then writes a parent sum for each
// tree level while the single read port of the node memory fetches the next
// sibling. A query request climbs the tree level by level, the one read port
// serving the left and right bounds on alternate cycles.
// An update that falls outside the active count is dropped.
// After reset the node memory is swept to zero, one node a cycle; no request
// is taken meanwhile, though configuration writes are.
// A finished sum waits in the output register, so the next request is taken
// while it is unread; a query only stalls at its end if that register is full.
`timescale 1ns / 1ps
module alternating_sign_range_sum_tree_unit
    import asrst_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [IN_TDATA_W-1:0] i_s_tdata,  // [9:0] position, [41:10] new_value,
                                              // [52:42] range_end, [55:53] zero
    input  logic                  i_s_tuser,  // [0] req_type
    // result stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [SUM_W-1:0]      o_m_tdata,  // [63:0] range_sum
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [2:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    t_cmd  w_cmd;
    t_stat w_stat;
    logic  [CNT_W-1:0] r_element_count;
    logic  signed [SUM_W-1:0] w_range_sum;
    logic  w_cfg_write;

    // The register decodes on the word address; the only register is word zero.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_element_count <= COUNT_RESET;
        end else if (w_cfg_write) begin
            r_element_count <= pwdata[CNT_W-1:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {{(32-CNT_W){1'b0}}, r_element_count} : '0;

    // Sequencing of the clearing sweep and of each request's tree walk.
    asrst_ctrl u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_valid (i_s_tvalid),
        .i_m_ready (i_m_tready),
        .i_stat    (w_stat),
        .o_cmd     (w_cmd),
        .o_s_ready (o_s_tready),
        .o_m_valid (o_m_tvalid)
    );

    // Node memory, bound pointers, accumulator and result register.
    asrst_dpath u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .i_element_count (r_element_count),
        .i_req_type      (i_s_tuser),
        .i_position      (i_s_tdata[POS_W-1:0]),
        .i_new_value     (i_s_tdata[POS_W+VAL_W-1:POS_W]),
        .i_range_end     (i_s_tdata[POS_W+VAL_W+END_W-1:POS_W+VAL_W]),
        .o_stat          (w_stat),
        .o_range_sum     (w_range_sum)
    );

    assign o_m_tdata = w_range_sum;

endmodule

/* tb/alternating_sign_range_sum_tree_unit_tb.sv */
// Self-checking testbench of the alternating-sign range sum tree unit.
`timescale 1ns / 1ps
module alternating_sign_range_sum_tree_unit_tb;
    import asrst_pkg::*;

    // Byte address of the element_count register on the APB port.
    localparam logic [2:0] ELEMENT_COUNT_ADDR = 3'd0;

    // After the last expected sum has arrived, this many cycles cover any
    // update that is still finishing its walk up the tree.
    localparam int SETTLE_CYCLES = 48;

    // Even with the longest gaps and stalls a correct run ends well inside this
    // limit, so the limit only catches a hung block.
    localparam int CYCLE_LIMIT = 500000;

    localparam int LONG_HOLD_CYCLES = 600;

    typedef enum logic [1:0] {
        READY_ALWAYS,
        READY_RANDOM,
        READY_PERIODIC
    } t_ready_mode;

    // Clock, reset and the block's ports.
    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_s_tvalid = 1'b0;
    logic                  o_s_tready;
    logic [IN_TDATA_W-1:0] i_s_tdata  = '0;  // [9:0] position, [41:10] new_value,
                                              // [52:42] range_end, [55:53] zero
    logic                  i_s_tuser  = REQ_UPDATE;  // [0] req_type
    logic                  o_m_tvalid;
    logic                  i_m_tready = 1'b0;
    logic [SUM_W-1:0]      o_m_tdata;  // [63:0] range_sum
    logic                  psel       = 1'b0;
    logic                  penable    = 1'b0;
    logic                  pwrite     = 1'b0;
    logic [2:0]            paddr      = '0;
    logic [31:0]           pwdata     = '0;
    logic [31:0]           prdata;
    logic                  pready;

    // Predictor state: the stored leaf values (already negated at odd
    // positions, exactly as the tree keeps them) and the element count.
    logic [SUM_W-1:0] leaf_store [MAX_LEAVES];
    logic [CNT_W-1:0] element_count_shadow;

    // Sums still owed by the block, oldest first.
    logic [SUM_W-1:0] expected_sums [$];

    // Bookkeeping for the checker and the summary.
    int error_count     = 0;
    int sums_checked    = 0;
    int updates_sent    = 0;
    int updates_stored  = 0;
    int queries_sent    = 0;
    int counts_written  = 0;
    int cycle_count     = 0;

    // Sender burst state, and the receiver's stall pattern.
    int          burst_left          = 0;
    int          hold_request_cycles = 0;
    int          hold_left           = 0;
    int          mode_left           = 0;
    int          pattern_phase       = 0;
    t_ready_mode ready_mode          = READY_ALWAYS;
    logic [SUM_W-1:0] expected_head;

    alternating_sign_range_sum_tree_unit i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    // 8 ns clock period.
    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Counts beyond the tree size behave as a full tree.
    function automatic int active_leaves();
        if (element_count_shadow > CNT_W'(MAX_LEAVES)) begin
            return MAX_LEAVES;
        end
        return int'(element_count_shadow);
    endfunction

    // Applies one accepted request to the predictor and, for a query, queues
    // the sum that the block must return. The sum is taken straight over the
    // leaves; since all arithmetic wraps at 64 bits this equals the tree walk.
    function automatic void predict_request(input logic kind,
                                            input logic [POS_W-1:0] pos,
                                            input logic [VAL_W-1:0] value,
                                            input logic [END_W-1:0] range_end);
        int               lim;
        int               stop;
        logic [SUM_W-1:0] leaf;
        logic [SUM_W-1:0] total;
        lim = active_leaves();
        if (kind == REQ_UPDATE) begin
            updates_sent++;
            if (int'(pos) < lim) begin
                // Sign-extend first, so the most negative value is negated exactly.
                leaf = {{(SUM_W-VAL_W){value[VAL_W-1]}}, value};
                if (pos[0]) begin
                    leaf = -leaf;
                end
                leaf_store[pos] = leaf;
                updates_stored++;
            end
        end else begin
            queries_sent++;
            stop  = (int'(range_end) > lim) ? lim : int'(range_end);
            total = '0;
            for (int i = int'(pos); i < stop; i++) begin
                total += leaf_store[i];
            end
            if (pos[0]) begin
                total = -total;
            end
            expected_sums.push_back(total);
        end
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offers one request and returns at the edge where it was taken. The
    // sender works in bursts: when a burst runs out, valid drops for a random
    // gap before the request goes out. Valid is never dropped between
    // requests within a burst, so it sees a single assignment per edge.
    task automatic send_request(input logic kind, input logic [POS_W-1:0] pos,
                                input logic [VAL_W-1:0] value,
                                input logic [END_W-1:0] range_end);
        int gap;
        if (burst_left <= 0) begin
            gap = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                               : $urandom_range(1, 6);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                      : $urandom_range(1, 10);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= kind;
        i_s_tdata  <= IN_TDATA_W'({range_end, value, pos});
        do @(posedge i_clk); while (!o_s_tready);
        burst_left--;
        predict_request(kind, pos, value, range_end);
    endtask

    // Drops valid, waits for every owed sum and then for any update that may
    // still be walking the tree. Register writes follow only after this.
    task automatic settle_idle();
        i_s_tvalid <= 1'b0;
        while (expected_sums.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // APB write: a setup phase, then an access phase whose closing edge
    // writes the register. The bus then idles before the task returns, so that
    // back-to-back writes never assign psel twice at one edge.
    task automatic write_element_count(input logic [CNT_W-1:0] count);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ELEMENT_COUNT_ADDR;
        pwdata  <= 32'(count);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        element_count_shadow = count;
        counts_written++;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Values lean towards the extremes of the 32-bit signed range.
    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0001;
            3: return '0;
            4: return 32'hFFFF_FFFF;
            default: return $urandom();
        endcase
    endfunction

    // One random request. Most updates land inside the active count so that
    // the tree fills with data; most queries are proper ranges, the rest
    // have random ends or are empty. The ignored field of each
    // request carries random bits as well.
    task automatic send_random_request(input int query_pct);
        int               lim;
        int               sel;
        logic [POS_W-1:0] pos;
        logic [END_W-1:0] range_end;
        lim = active_leaves();
        sel = $urandom_range(0, 99);
        if (lim > 0 && $urandom_range(0, 9) != 0) begin
            pos = POS_W'($urandom_range(0, lim - 1));
        end else begin
            pos = POS_W'($urandom());
        end
        if ($urandom_range(0, 99) >= query_pct) begin
            send_request(REQ_UPDATE, pos, random_value(), END_W'($urandom()));
        end else begin
            if (sel < 70) begin
                range_end = END_W'($urandom_range(int'(pos), lim));
            end else if (sel < 85) begin
                range_end = END_W'($urandom());
            end else begin
                range_end = END_W'($urandom_range(0, int'(pos)));
            end
            send_request(REQ_QUERY, pos, VAL_W'($urandom()), range_end);
        end
    endtask

    // ------------------------------------------------------------------
    // Result checker and receiver stall pattern
    // ------------------------------------------------------------------

    function automatic void report_error(input string msg);
        if (error_count < 10) begin
            $display("ERROR at cycle %0d: %s", cycle_count, msg);
        end
        error_count++;
    endfunction

    // Every taken result is compared with the oldest owed sum. Ready then
    // follows the current stall mode, unless a long hold was asked for, which
    // this process counts down itself.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_sums.size() == 0) begin
                report_error($sformatf("unexpected sum %0d", $signed(o_m_tdata)));
            end else begin
                expected_head = expected_sums.pop_front();
                sums_checked++;
                if (o_m_tdata !== expected_head) begin
                    report_error($sformatf("range_sum expected %0d (%h), got %0d (%h)",
                                           $signed(expected_head), expected_head,
                                           $signed(o_m_tdata), o_m_tdata));
                end
            end
        end

        if (hold_request_cycles > 0) begin
            hold_left           = hold_request_cycles;
            hold_request_cycles = 0;
        end
        if (mode_left <= 0) begin
            ready_mode = t_ready_mode'($urandom_range(0, 2));
            mode_left  = $urandom_range(20, 200);
        end else begin
            mode_left--;
        end
        pattern_phase = (pattern_phase + 1) % 7;

        if (hold_left > 0) begin
            hold_left--;
            i_m_tready <= 1'b0;
        end else begin
            case (ready_mode)
                READY_ALWAYS:   i_m_tready <= 1'b1;
                READY_RANDOM:   i_m_tready <= 1'($urandom_range(0, 1));
                READY_PERIODIC: i_m_tready <= (pattern_phase < 2);
                default:        i_m_tready <= 1'b1;
            endcase
        end
    end

    // Watchdog: a hung block or a sum that never arrives ends the run here.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("alternating_sign_range_sum_tree_unit_tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Full tree: the largest and smallest values at even and odd positions,
    // the last leaf, whole-array queries, an end clipped to the count, empty
    // and reversed ranges, and odd starts that flip the sign of the answer.
    task automatic test_directed_extremes();
        write_element_count(CNT_W'(MAX_LEAVES));
        send_request(REQ_UPDATE, 10'd0,    32'h7FFF_FFFF, 11'd0);
        send_request(REQ_UPDATE, 10'd1,    32'h8000_0000, 11'd2047);
        send_request(REQ_UPDATE, 10'd2,    32'h8000_0001, 11'd0);
        send_request(REQ_UPDATE, 10'd3,    32'hFFFF_FFFF, 11'd0);
        send_request(REQ_UPDATE, 10'd512,  32'h1234_5678, 11'd0);
        send_request(REQ_UPDATE, 10'd1022, 32'h7FFF_FFFF, 11'd0);
        send_request(REQ_UPDATE, 10'd1023, 32'h8000_0000, 11'd0);
        send_request(REQ_QUERY,  10'd0,    32'hFFFF_FFFF, 11'd1024);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd2047);
        send_request(REQ_QUERY,  10'd1,    32'h0,         11'd4);
        send_request(REQ_QUERY,  10'd1,    32'h0,         11'd2);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd1);
        send_request(REQ_QUERY,  10'd5,    32'h0,         11'd5);
        send_request(REQ_QUERY,  10'd9,    32'h0,         11'd3);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd0);
        send_request(REQ_QUERY,  10'd1023, 32'h0,         11'd1024);
        send_request(REQ_QUERY,  10'd1023, 32'h0,         11'd2047);
        send_request(REQ_QUERY,  10'd1022, 32'h0,         11'd1024);
        send_request(REQ_QUERY,  10'd511,  32'h0,         11'd1000);
        send_request(REQ_UPDATE, 10'd1,    32'h0000_0005, 11'd0);
        send_request(REQ_QUERY,  10'd1,    32'h0,         11'd1024);
        settle_idle();
    endtask

    // Count settings at the edges: zero (everything ignored, every query
    // empty), one and two leaves, and counts above the tree size, which
    // behave as a full tree.
    task automatic test_count_settings();
        write_element_count(11'd0);
        send_request(REQ_UPDATE, 10'd0,    32'h0000_0005, 11'd0);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd1024);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd0);
        settle_idle();

        write_element_count(11'd1);
        send_request(REQ_UPDATE, 10'd0,    32'hFFFF_FFF9, 11'd0);
        send_request(REQ_UPDATE, 10'd1,    32'h0000_0063, 11'd0);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd1024);
        send_request(REQ_QUERY,  10'd1,    32'h0,         11'd2047);
        settle_idle();

        write_element_count(11'd2);
        send_request(REQ_UPDATE, 10'd1,    32'h8000_0000, 11'd0);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd2);
        send_request(REQ_QUERY,  10'd1,    32'h0,         11'd3);
        settle_idle();

        write_element_count(11'd1025);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd1024);
        send_request(REQ_UPDATE, 10'd1023, 32'h0000_002A, 11'd0);
        send_request(REQ_QUERY,  10'd1000, 32'h0,         11'd2047);
        settle_idle();

        write_element_count(11'd2047);
        send_request(REQ_UPDATE, 10'd1021, 32'h7FFF_FFFF, 11'd0);
        send_request(REQ_QUERY,  10'd0,    32'h0,         11'd2047);
        send_request(REQ_QUERY,  10'd1021, 32'h0,         11'd1500);
        settle_idle();
    endtask

    // Random traffic in phases, each under its own element count. Updates
    // lead in the first phase so that the tree is full of data before most
    // of the queries run.
    task automatic test_random_traffic();
        int phase_counts [8];
        int phase_items  [8];
        int phase_query  [8];
        phase_counts = '{MAX_LEAVES, 0, 2047, 3, 1, 0, 0, MAX_LEAVES};
        phase_items  = '{300, 200, 200, 100, 60, 40, 200, 300};
        phase_query  = '{30, 55, 55, 55, 55, 80, 55, 60};
        phase_counts[1] = $urandom_range(1, MAX_LEAVES);
        phase_counts[6] = $urandom_range(MAX_LEAVES / 2 + 1, MAX_LEAVES - 1);
        for (int p = 0; p < 8; p++) begin
            write_element_count(CNT_W'(phase_counts[p]));
            repeat (phase_items[p]) send_random_request(phase_query[p]);
            settle_idle();
        end
    endtask

    // The receiver stops taking sums for a long stretch while the sender
    // keeps offering requests with no gaps, so the output register fills and
    // the request side has to stall.
    task automatic test_output_backpressure();
        write_element_count(CNT_W'(MAX_LEAVES));
        hold_request_cycles = LONG_HOLD_CYCLES;
        burst_left          = 1000;
        repeat (40) send_random_request(75);
        burst_left = 0;
        settle_idle();
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        for (int i = 0; i < MAX_LEAVES; i++) begin
            leaf_store[i] = '0;
        end
        element_count_shadow = COUNT_RESET;

        // The block clears its node memory after reset and takes no request
        // until that is done; the first request simply waits for ready.
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_count_settings();
        test_random_traffic();
        test_output_backpressure();

        $display("Covered %0d updates (%0d stored) and %0d range queries across %0d count settings.",
                 updates_sent, updates_stored, queries_sent, counts_written);
        $display("Checked %0d sums, including a %0d-cycle hold on the result side.",
                 sums_checked, LONG_HOLD_CYCLES);
        if (error_count == 0 && expected_sums.size() == 0) begin
            $display("alternating_sign_range_sum_tree_unit_tb passed");
        end else begin
            $display("alternating_sign_range_sum_tree_unit_tb failed");
        end
        $finish;
    end

endmodule
